// ===== rtl/hgp_pkg.sv =====
// Shared types, codes and constants for the header image grey packer.
// Used by every module of the block; depends on nothing else.
package hgp_pkg;

  // Offset of the first printable character of the image encoding.
  localparam logic [7:0] SEXTET_OFFSET = 8'd33;

  // Q10 luma weights (0.30, 0.59 and 0.11 scaled by 1024).
  localparam logic [9:0] WEIGHT_R = 10'd307;
  localparam logic [9:0] WEIGHT_G = 10'd604;
  localparam logic [9:0] WEIGHT_B = 10'd113;

  // One-bit mode threshold.
  localparam logic [7:0] GREY_THRESHOLD = 8'd128;

  // Register widths and reset values.
  localparam int unsigned CFG_DATA_W    = 11;
  localparam int unsigned ADDR_W        = 20;
  localparam logic [1:0]  MODE_RESET    = 2'd2;
  localparam logic [10:0] WIDTH_RESET   = 11'd320;
  localparam logic [10:0] HEIGHT_RESET  = 11'd240;

  // Default size limits.
  localparam int unsigned MAX_WIDTH_DEFAULT  = 1024;
  localparam int unsigned MAX_HEIGHT_DEFAULT = 1024;

  // Depth of the queue between decode and packing.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    CFG_DEPTH_MODE   = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_index_t;

  // Pixel depth codes; the unused code packs as eight bits.
  typedef enum logic [1:0] {
    DEPTH_1BPP = 2'd0,
    DEPTH_4BPP = 2'd1,
    DEPTH_8BPP = 2'd2
  } depth_mode_t;

  // One decoded pixel.
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // A configuration write transaction handed to the packer.
  typedef struct packed {
    logic                  valid;
    logic [1:0]            index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

// ===== rtl/hgp_queue.sv =====
// Short FIFO of decoded pixels between the character decoder and the packer.
// Depends on hgp_pkg for the pixel type.
module hgp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  hgp_pkg::rgb_t push_data,
  input  logic        pop,
  output logic        not_empty,
  output logic        full,
  output hgp_pkg::rgb_t pop_data
);
  import hgp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rgb_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(DEPTH));
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/hgp_front.sv =====
// Character decoder: gathers four sextets and forms one RGB pixel.
// Depends on hgp_pkg for the pixel type and the character offset.
module hgp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          char_valid,
  input  logic          queue_full,
  input  logic [7:0]    char_code,
  output logic          char_stall,
  output logic          push,
  output hgp_pkg::rgb_t push_data
);
  import hgp_pkg::*;

  logic [1:0]  char_phase;
  logic [17:0] held_sextets;
  logic [5:0]  sextet;
  logic [5:0]  s0;
  logic [5:0]  s1;
  logic [5:0]  s2;
  logic        accept;

  assign char_stall = queue_full;
  assign accept     = char_valid && !char_stall;
  assign sextet     = 6'(char_code - SEXTET_OFFSET);

  assign s0 = held_sextets[17:12];
  assign s1 = held_sextets[11:6];
  assign s2 = held_sextets[5:0];

  // The fourth character completes a pixel and goes straight to the queue.
  assign push        = accept && (char_phase == 2'd3);
  assign push_data.r = {s0, s1[5:4]};
  assign push_data.g = {s1[3:0], s2[5:2]};
  assign push_data.b = {s2[1:0], sextet};

  // Sextet collection.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_phase   <= '0;
      held_sextets <= '0;
    end else if (accept) begin
      if (char_phase == 2'd3) begin
        char_phase   <= '0;
        held_sextets <= '0;
      end else begin
        char_phase   <= char_phase + 1'b1;
        held_sextets <= {held_sextets[11:0], sextet};
      end
    end
  end

endmodule

// ===== rtl/hgp_back.sv =====
// Packer: converts pixels to grey, packs them by depth and emits addressed bytes.
// Holds the configuration registers; depends on hgp_pkg.
module hgp_back #(
  parameter int unsigned MAX_WIDTH  = hgp_pkg::MAX_WIDTH_DEFAULT,
  parameter int unsigned MAX_HEIGHT = hgp_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  hgp_pkg::cfg_wr_t          cfg_wr,
  input  logic                      queue_not_empty,
  input  hgp_pkg::rgb_t             pixel,
  output logic                      pop,
  input  logic                      byte_stall,
  output logic                      byte_valid,
  output logic [7:0]                pixel_byte,
  output logic [hgp_pkg::ADDR_W-1:0] byte_address,
  output logic                      frame_last
);
  import hgp_pkg::*;

  localparam int unsigned WW      = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW      = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned TOTAL_W = WW + HW;

  // Configuration registers.
  logic [1:0]            pixel_depth_mode;
  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;

  // Packing state.
  logic [2:0]        pixel_in_byte;
  logic [7:0]        partial_byte;
  logic [ADDR_W-1:0] byte_counter;
  logic [TOTAL_W-1:0] frame_total;

  logic [2:0]         pixel_in_byte_next;
  logic [7:0]         partial_byte_next;
  logic               emit;
  logic [7:0]         emit_value;
  logic [17:0]        weighted_sum;
  logic [7:0]         grey;
  logic [WW-1:0]      width_clamp;
  logic [HW-1:0]      height_clamp;
  logic [WW-1:0]      per_line;
  logic               is_last;
  logic               out_free;

  // Configuration writes; a depth change drops the partly packed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_depth_mode <= MODE_RESET;
      frame_width      <= WIDTH_RESET;
      frame_height     <= HEIGHT_RESET;
    end else if (cfg_wr.valid) begin
      case (cfg_index_t'(cfg_wr.index))
        CFG_DEPTH_MODE:   pixel_depth_mode <= cfg_wr.data[1:0];
        CFG_FRAME_WIDTH:  frame_width      <= cfg_wr.data;
        CFG_FRAME_HEIGHT: frame_height     <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Frame size in bytes, registered off the configuration registers.
  always_comb begin
    width_clamp  = (32'(frame_width) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(frame_width);
    height_clamp = (32'(frame_height) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
                                                          : HW'(frame_height);
    case (depth_mode_t'(pixel_depth_mode))
      DEPTH_1BPP: per_line = width_clamp >> 3;
      DEPTH_4BPP: per_line = width_clamp >> 1;
      default:    per_line = width_clamp;
    endcase
  end

  always_ff @(posedge clk) begin
    frame_total <= TOTAL_W'(per_line) * TOTAL_W'(height_clamp);
  end

  // Luma weighting with constant coefficients.
  assign weighted_sum = 18'(WEIGHT_R) * 18'(pixel.r) + 18'(WEIGHT_G) * 18'(pixel.g)
                      + 18'(WEIGHT_B) * 18'(pixel.b);
  assign grey = weighted_sum[17:10];

  // Take a pixel whenever the output register is free or being drained.
  assign out_free = !byte_valid || !byte_stall;
  assign pop      = queue_not_empty && out_free;

  // Pack the grey value according to the depth mode.
  always_comb begin
    emit               = 1'b0;
    emit_value         = grey;
    pixel_in_byte_next = '0;
    partial_byte_next  = '0;
    case (depth_mode_t'(pixel_depth_mode))
      DEPTH_4BPP: begin
        if (pixel_in_byte == 3'd0) begin
          partial_byte_next  = {4'd0, grey[7:4]};
          pixel_in_byte_next = 3'd1;
        end else begin
          emit       = 1'b1;
          emit_value = {grey[7:4], partial_byte[3:0]};
        end
      end
      DEPTH_1BPP: begin
        partial_byte_next = partial_byte;
        if (grey >= GREY_THRESHOLD) begin
          partial_byte_next[3'd7 - pixel_in_byte] = 1'b1;
        end
        if (pixel_in_byte == 3'd7) begin
          emit              = 1'b1;
          emit_value        = partial_byte_next;
          partial_byte_next = '0;
        end else begin
          pixel_in_byte_next = pixel_in_byte + 1'b1;
        end
      end
      default: begin
        emit = 1'b1;
      end
    endcase
  end

  // End of frame: the counter reaches the last byte, or the frame is empty.
  assign is_last = (frame_total == '0) || (32'(byte_counter) + 32'd1 >= 32'(frame_total));

  // Packing state and byte counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_in_byte <= '0;
      partial_byte  <= '0;
      byte_counter  <= '0;
    end else if (cfg_wr.valid && (cfg_index_t'(cfg_wr.index) == CFG_DEPTH_MODE)) begin
      pixel_in_byte <= '0;
      partial_byte  <= '0;
    end else if (pop) begin
      pixel_in_byte <= pixel_in_byte_next;
      partial_byte  <= partial_byte_next;
      if (emit) begin
        byte_counter <= is_last ? '0 : byte_counter + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (pop && emit) begin
      byte_valid <= 1'b1;
    end else if (!byte_stall) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      pixel_byte   <= emit_value;
      byte_address <= (frame_total == '0) ? '0 : byte_counter;
      frame_last   <= is_last;
    end
  end

endmodule

// ===== rtl/header_image_to_grey_packer_top.sv =====
// Header image grey packer. Accepts one image character per cycle unless stalled;
// every fourth character completes an RGB pixel that is converted to grey (Q10
// luma weights) and packed at one, four or eight bits per pixel into addressed
// frame-buffer bytes, at most one byte per cycle. A two-entry pixel queue
// separates the character decoder from the packer, so a stalled byte output
// holds the input off only once both queue entries are full. The configuration
// port never stalls and must only be written while the block is idle.
module header_image_to_grey_packer_top #(
  parameter int unsigned MAX_WIDTH  = hgp_pkg::MAX_WIDTH_DEFAULT,
  parameter int unsigned MAX_HEIGHT = hgp_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          char_valid,
  output logic                          char_stall,
  input  logic [7:0]                    char_code,
  output logic                          byte_valid,
  input  logic                          byte_stall,
  output logic [7:0]                    pixel_byte,
  output logic [hgp_pkg::ADDR_W-1:0]    byte_address,
  output logic                          frame_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [hgp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hgp_pkg::*;

  logic    push;
  rgb_t    push_data;
  logic    pop;
  logic    queue_not_empty;
  logic    queue_full;
  rgb_t    pop_data;
  cfg_wr_t cfg_wr;

  // Configuration transactions are always taken.
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // Character decoder.
  hgp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .queue_full (queue_full),
    .char_code  (char_code),
    .char_stall (char_stall),
    .push       (push),
    .push_data  (push_data)
  );

  // Pixel queue.
  hgp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (queue_not_empty),
    .full      (queue_full),
    .pop_data  (pop_data)
  );

  // Grey conversion and byte packing.
  hgp_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr          (cfg_wr),
    .queue_not_empty (queue_not_empty),
    .pixel           (pop_data),
    .pop             (pop),
    .byte_stall      (byte_stall),
    .byte_valid      (byte_valid),
    .pixel_byte      (pixel_byte),
    .byte_address    (byte_address),
    .frame_last      (frame_last)
  );

endmodule
